>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of the servo PID block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while the reset is high.
`define SIPID_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define SIPID_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sipid_pkg.sv
// Package of the servo incremental PID block: field widths, codes, reset values,
// reciprocal constants and the structs passed between the modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sipid_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 12;

  // Mode codes of an input request; the spare code behaves as idle.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_DUTY  = 2'd1;
  localparam logic [1:0] MODE_ANGLE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_DUTY_LIMIT     = 3'd0;
  localparam logic [2:0] CFG_POSITION_LOW   = 3'd1;
  localparam logic [2:0] CFG_POSITION_HIGH  = 3'd2;
  localparam logic [2:0] CFG_ERROR_DEADBAND = 3'd3;
  localparam logic [2:0] CFG_REWRITE_MARGIN = 3'd4;

  // Register values after reset.
  localparam logic [15:0] RST_DUTY_LIMIT     = 16'd1000;
  localparam logic [11:0] RST_POSITION_LOW   = 12'd100;
  localparam logic [11:0] RST_POSITION_HIGH  = 12'd3800;
  localparam logic [7:0]  RST_ERROR_DEADBAND = 8'd10;
  localparam logic [9:0]  RST_REWRITE_MARGIN = 10'd50;

  localparam logic [15:0] DUTY_MAG_MAX = 16'hFFFF;

  // Exact truncating division by reciprocal multiplication.
  // x / 20 for x < 2^14: (x * 26215) >> 19.
  localparam logic [27:0] DIV20_MUL   = 28'd26215;
  // x / 100 for x < 2^23: (x * 10737419) >> 30.
  localparam logic [46:0] DIV100_MUL  = 47'd10737419;

  localparam logic signed [31:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SUM_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [15:0] duty_limit;
    logic [11:0] position_low;
    logic [11:0] position_high;
    logic [7:0]  error_deadband;
    logic [9:0]  rewrite_margin;
  } cfg_t;

  typedef struct packed {
    logic                  channel;
    logic [SAMPLE_BITS-1:0] position;
    logic [1:0]            mode;
    logic [SAMPLE_BITS-1:0] target;
    logic signed [16:0]    duty_request;
  } item_t;

  // PID history of one channel.
  typedef struct packed {
    logic signed [13:0] previous_error;
    logic signed [13:0] older_error;
    logic signed [31:0] duty_sum;
  } hist_t;

  // Contents of the register between the sum stage and the duty stage.
  typedef struct packed {
    logic               channel;
    logic signed [31:0] duty_sum;
    logic [15:0]        limit;
  } mid_t;

endpackage

`default_nettype wire

>>> hw/rtl/sipid_accum.sv
// Sum stage of the servo PID: target clamp, error with deadband and the
// saturating incremental PID sum. Depends on sipid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sipid_accum import sipid_pkg::*; (
  input  item_t       item,
  input  cfg_t        cfg,
  input  hist_t       hist,
  output hist_t       hist_next,
  output logic [15:0] limit
);

  logic               req_neg;
  logic               req_pos;
  logic [16:0]        req_mag;
  logic [15:0]        duty_lim;
  logic [11:0]        tgt_raw;
  logic [11:0]        tgt_lo;
  logic [11:0]        tgt;
  logic signed [13:0] diff;
  logic [12:0]        diff_mag;
  logic signed [13:0] err;
  logic [12:0]        err_mag;
  logic [27:0]        div_prod;
  logic [8:0]         div_q;
  logic signed [25:0] e_w;
  logic signed [25:0] e1_w;
  logic signed [25:0] e2_w;
  logic signed [25:0] q_w;
  logic signed [25:0] prop_t;
  logic signed [25:0] der_t;
  logic signed [25:0] delta;
  logic signed [33:0] sum_w;
  logic signed [31:0] sum_sat;
  logic               run;
  logic               quiet;

  assign req_neg  = item.duty_request[16];
  assign req_pos  = !req_neg && (item.duty_request != 17'sd0);
  // A request of -65536 has magnitude 65536 and is limited to 65535.
  assign req_mag  = req_neg ? 17'(-item.duty_request) : item.duty_request;
  assign duty_lim = req_mag[16] ? DUTY_MAG_MAX : req_mag[15:0];

  always_comb begin
    if (item.mode == MODE_DUTY) begin
      tgt_raw = req_pos ? cfg.position_high :
                req_neg ? cfg.position_low : item.position;
    end else begin
      tgt_raw = item.target;
    end
    // Raise to the low limit first, then lower to the high limit.
    tgt_lo = (tgt_raw < cfg.position_low) ? cfg.position_low : tgt_raw;
    tgt    = (tgt_lo > cfg.position_high) ? cfg.position_high : tgt_lo;
  end

  // Both operands are 12-bit, so the difference never leaves the 14-bit
  // error range and needs no saturation.
  assign diff     = $signed({2'b00, tgt}) - $signed({2'b00, item.position});
  assign diff_mag = diff[13] ? 13'(-diff) : diff[12:0];
  assign err      = (diff_mag < {5'b0, cfg.error_deadband}) ? 14'sd0 : diff;
  assign err_mag  = (err == 14'sd0) ? 13'd0 : diff_mag;

  // Integral term 50*e/1000 is e/20 truncated toward zero.
  assign div_prod = {15'b0, err_mag} * DIV20_MUL;
  assign div_q    = div_prod[27:19];
  assign q_w      = err[13] ? -$signed({17'b0, div_q}) : $signed({17'b0, div_q});

  assign e_w  = 26'(err);
  assign e1_w = 26'(hist.previous_error);
  assign e2_w = 26'(hist.older_error);

  assign prop_t = (e_w - e1_w) * 26'sd100;
  assign der_t  = (e_w - (e1_w <<< 1) + e2_w) * 26'sd50;
  assign delta  = prop_t + q_w + der_t;
  assign sum_w  = 34'(hist.duty_sum) + 34'(delta);

  always_comb begin
    if (sum_w[33:31] == 3'b000 || sum_w[33:31] == 3'b111) begin
      sum_sat = sum_w[31:0];
    end else begin
      sum_sat = sum_w[33] ? SUM_MIN : SUM_MAX;
    end
  end

  assign run   = (item.mode == MODE_DUTY) || (item.mode == MODE_ANGLE);
  assign quiet = (err == 14'sd0) && (hist.previous_error == 14'sd0);

  always_comb begin
    if (run) begin
      hist_next.previous_error = err;
      hist_next.older_error    = hist.previous_error;
      hist_next.duty_sum       = quiet ? 32'sd0 : sum_sat;
    end else begin
      // Idle clears the history; a zero sum then yields a zero duty.
      hist_next = '0;
    end
  end

  assign limit = (item.mode == MODE_DUTY) ? duty_lim : cfg.duty_limit;

endmodule

`default_nettype wire

>>> hw/rtl/sipid_duty.sv
// Duty stage of the servo PID: sum divided by 100, clamp to the limit and the
// motor rewrite decision against the held duty. Depends on sipid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sipid_duty import sipid_pkg::*; (
  input  mid_t               mid,
  input  logic signed [16:0] held,
  input  logic [9:0]         rewrite_margin,
  output logic signed [16:0] duty,
  output logic               rewrite
);

  logic               neg;
  logic [31:0]        mag;
  logic [22:0]        x;
  logic [46:0]        prod;
  logic [16:0]        q;
  logic [16:0]        qc;
  logic signed [17:0] delta;
  logic [17:0]        delta_mag;
  logic               sign_diff;

  assign neg = mid.duty_sum[31];
  assign mag = neg ? 32'(-mid.duty_sum) : mid.duty_sum;
  // Any magnitude of 2^23 or more gives a quotient above every limit,
  // so it is pinned before the divide.
  assign x    = (mag[31:23] != 9'd0) ? {23{1'b1}} : mag[22:0];
  assign prod = {24'b0, x} * DIV100_MUL;
  assign q    = prod[46:30];
  assign qc   = (q > {1'b0, mid.limit}) ? {1'b0, mid.limit} : q;
  assign duty = neg ? -$signed(qc) : $signed(qc);

  assign delta     = 18'(duty) - 18'(held);
  assign delta_mag = delta[17] ? 18'(-delta) : delta;
  assign sign_diff = (duty[16] != held[16]) ||
                     ((duty == 17'sd0) != (held == 17'sd0));
  assign rewrite   = sign_diff || (delta_mag > {8'b0, rewrite_margin});

endmodule

`default_nettype wire

>>> hw/rtl/servo_incremental_pid_unit.sv
// Top level of the servo incremental PID controller: handshakes, configuration
// registers, per-channel history and the pipeline. Uses sipid_pkg, sipid_accum
// and sipid_duty.
//
//  Channel  | Direction | Carries
//  s_axis   | in        | one control tick request: channel, mode, position, target, duty request
//  m_axis   | out       | one result request per tick: channel, held duty, rewrite flag, compares
//  cfg      | in        | register writes by index, always ready
//
// A request is carried by the input register, the middle register and the result register in turn:
// the input register feeds the sum stage, the sum stage fills the middle register and the
// duty stage fills the result register.
// One request is accepted every cycle unless a stalled result has filled the stages; the sum loop
// through the channel history and the rewrite loop through the held duty each close within one stage.
// Reset clears the registers to their documented values, all channel history
// and all held duties; there is no clearing pass.
// A stalled result only blocks the stages behind it once they are all full.
`timescale 1ns / 1ps
`default_nettype none

module servo_incremental_pid_unit import sipid_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from 0: position[11:0], target[23:12], duty_request[40:24], zeros[47:41]
  input  logic [47:0] s_axis_tdata,
  // Bits from 0: channel[0], mode[2:1]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from 0: duty[16:0], rewritten[17], forward_compare[33:18],
  // reverse_compare[49:34], zeros[55:50]
  output logic [55:0] m_axis_tdata,
  // Bits from 0: out_channel[0]
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  hist_t hist [CHANNELS];
  logic signed [16:0] applied [CHANNELS];

  // Pipeline registers.
  logic  in_valid;
  item_t in_item;
  logic  mid_valid;
  mid_t  mid;
  logic  out_valid;
  logic               out_channel;
  logic signed [16:0] out_duty;
  logic               out_rewritten;
  logic [15:0]        out_forward;
  logic [15:0]        out_reverse;

  // Stage advance: each stage moves when the one after it can take its content.
  logic out_adv;
  logic mid_adv;
  logic in_adv;

  hist_t              hist_next;
  logic [15:0]        limit;
  logic signed [16:0] duty_new;
  logic               rewrite;
  logic signed [16:0] held_cur;
  logic signed [16:0] held_next;

  assign out_adv = !out_valid || m_axis_tready;
  assign mid_adv = !mid_valid || out_adv;
  assign in_adv  = !in_valid || mid_adv;

  assign s_axis_tready = in_adv;
  assign cfg_ready     = 1'b1;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_limit     <= RST_DUTY_LIMIT;
      cfg.position_low   <= RST_POSITION_LOW;
      cfg.position_high  <= RST_POSITION_HIGH;
      cfg.error_deadband <= RST_ERROR_DEADBAND;
      cfg.rewrite_margin <= RST_REWRITE_MARGIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DUTY_LIMIT:     cfg.duty_limit     <= cfg_data;
        CFG_POSITION_LOW:   cfg.position_low   <= cfg_data[11:0];
        CFG_POSITION_HIGH:  cfg.position_high  <= cfg_data[11:0];
        CFG_ERROR_DEADBAND: cfg.error_deadband <= cfg_data[7:0];
        CFG_REWRITE_MARGIN: cfg.rewrite_margin <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Sum stage: reads and updates the history of the tick's channel in the same
  // cycle, so the next tick of that channel always sees the fresh values.
  sipid_accum u_accum (
    .item      (in_item),
    .cfg       (cfg),
    .hist      (hist[in_item.channel]),
    .hist_next (hist_next),
    .limit     (limit)
  );

  // Duty stage: the held duty is read and written here, in request order.
  assign held_cur = applied[mid.channel];

  sipid_duty u_duty (
    .mid            (mid),
    .held           (held_cur),
    .rewrite_margin (cfg.rewrite_margin),
    .duty           (duty_new),
    .rewrite        (rewrite)
  );

  assign held_next = rewrite ? duty_new : held_cur;

  // Valid flags and channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        hist[i]    <= '0;
        applied[i] <= 17'sd0;
      end
    end else begin
      if (in_adv) begin
        in_valid <= s_axis_tvalid;
      end
      if (mid_adv) begin
        mid_valid <= in_valid;
      end
      if (out_adv) begin
        out_valid <= mid_valid;
      end
      if (in_valid && mid_adv) begin
        hist[in_item.channel] <= hist_next;
      end
      if (mid_valid && out_adv) begin
        applied[mid.channel] <= held_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_adv) begin
      in_item.channel      <= s_axis_tuser[0];
      in_item.mode         <= s_axis_tuser[2:1];
      in_item.position     <= s_axis_tdata[11:0];
      in_item.target       <= s_axis_tdata[23:12];
      in_item.duty_request <= s_axis_tdata[40:24];
    end
    if (in_valid && mid_adv) begin
      mid.channel  <= in_item.channel;
      mid.duty_sum <= hist_next.duty_sum;
      mid.limit    <= limit;
    end
    if (mid_valid && out_adv) begin
      out_channel   <= mid.channel;
      out_duty      <= held_next;
      out_rewritten <= rewrite;
      out_forward   <= (!held_next[16] && held_next != 17'sd0) ? held_next[15:0] : 16'd0;
      out_reverse   <= held_next[16] ? 16'(-held_next) : 16'd0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_reverse, out_forward, out_rewritten, out_duty};
  assign m_axis_tuser  = out_channel;

endmodule

`default_nettype wire

>>> hw/rtl/sipid_checker.sv
// Port-level checks of the servo PID top level, bound to it below.
// Depends on assert_macros.svh and servo_incremental_pid_unit.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sipid_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [55:0] m_axis_tdata,
  input wire [0:0]  m_axis_tuser
);

  logic [16:0] duty;
  logic [16:0] duty_neg;
  logic [15:0] fwd;
  logic [15:0] rev;

  assign duty     = m_axis_tdata[16:0];
  assign duty_neg = -duty;
  assign fwd      = m_axis_tdata[33:18];
  assign rev      = m_axis_tdata[49:34];

  `SIPID_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !m_axis_tvalid, "result valid after reset")
  `SIPID_ASSERT(a_stall_holds, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `SIPID_ASSERT(a_forward, clk, rst, m_axis_tvalid && !duty[16] |-> fwd == duty[15:0] && rev == 16'd0, "forward compare does not match duty")
  `SIPID_ASSERT(a_reverse, clk, rst, m_axis_tvalid && duty[16] |-> rev == duty_neg[15:0] && fwd == 16'd0, "reverse compare does not match duty")

endmodule

bind servo_incremental_pid_unit sipid_checker u_checker (.*);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking bench for servo_incremental_pid_unit: directed and random control ticks,
// register writes between phases, and a tick-by-tick prediction of every result.
// Depends on sipid_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_top;
  import sipid_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 200;

  // One result request of the block, laid out field by field.
  typedef struct packed {
    logic               ch;
    logic signed [16:0] duty;
    logic               rewritten;
    logic [15:0]        fwd;
    logic [15:0]        rev;
  } tick_result_t;

  // Predicts the held duty of each channel and checks results in order.
  class servo_pid_checker;
    bit [15:0]        duty_limit;
    bit [11:0]        pos_low;
    bit [11:0]        pos_high;
    bit [7:0]         deadband;
    bit [9:0]         margin;
    bit signed [13:0] prev_err[CHANNELS];
    bit signed [13:0] older_err[CHANNELS];
    bit signed [31:0] duty_sum[CHANNELS];
    bit signed [16:0] held_duty[CHANNELS];
    tick_result_t     expected_ticks[$];
    int errors, checked, rewrites, angle_ticks, duty_ticks, idle_ticks, writes;

    function new();
      duty_limit = RST_DUTY_LIMIT;
      pos_low    = RST_POSITION_LOW;
      pos_high   = RST_POSITION_HIGH;
      deadband   = RST_ERROR_DEADBAND;
      margin     = RST_REWRITE_MARGIN;
      for (int i = 0; i < CHANNELS; i++) begin
        prev_err[i] = 0;
        older_err[i] = 0;
        duty_sum[i] = 0;
        held_duty[i] = 0;
      end
    endfunction

    function void write_register(bit [2:0] idx, bit [15:0] value);
      writes++;
      case (idx)
        CFG_DUTY_LIMIT:     duty_limit = value;
        CFG_POSITION_LOW:   pos_low = value[11:0];
        CFG_POSITION_HIGH:  pos_high = value[11:0];
        CFG_ERROR_DEADBAND: deadband = value[7:0];
        CFG_REWRITE_MARGIN: margin = value[9:0];
        default: ;
      endcase
    endfunction

    function int sign3(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // One PID step of a channel; returns the clamped duty before the rewrite decision.
    function longint pid_duty(int ch, longint pos, bit [1:0] mode, longint tgt, longint req);
      longint target, limit, e, e1, e2, sum;
      if (mode == MODE_DUTY) begin
        if (req > 0) target = longint'(pos_high);
        else if (req < 0) target = longint'(pos_low);
        else target = pos;
        limit = (req < 0) ? -req : req;
        if (limit > 65535) limit = 65535;
      end else begin
        target = tgt;
        limit = longint'(duty_limit);
      end
      // Low limit first, so crossed limits end up at the high one.
      if (target < longint'(pos_low)) target = longint'(pos_low);
      if (target > longint'(pos_high)) target = longint'(pos_high);
      e = target - pos;
      if (e > 8191) e = 8191;
      if (e < -8192) e = -8192;
      if (e > -longint'(deadband) && e < longint'(deadband)) e = 0;
      e1 = longint'(prev_err[ch]);
      e2 = longint'(older_err[ch]);
      older_err[ch] = prev_err[ch];
      prev_err[ch] = 14'(e);
      // A quiet loop drops the accumulated sum.
      if (e == 0 && e1 == 0) begin
        duty_sum[ch] = 0;
        return 0;
      end
      sum = longint'(duty_sum[ch]) + 100 * (e - e1) + (e * 50) / 1000
          + 50 * (e - 2 * e1 + e2);
      if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
      if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
      duty_sum[ch] = 32'(sum);
      sum = sum / 100;
      if (sum > limit) sum = limit;
      if (sum < -limit) sum = -limit;
      return sum;
    endfunction

    function void note_tick(bit ch, bit [11:0] pos, bit [1:0] mode, bit [11:0] tgt,
                            bit signed [16:0] req);
      tick_result_t r;
      longint d, cur, delta, h;
      r = '0;
      r.ch = ch;
      cur = longint'(held_duty[ch]);
      if (mode == MODE_DUTY || mode == MODE_ANGLE) begin
        if (mode == MODE_DUTY) duty_ticks++;
        else angle_ticks++;
        d = pid_duty(ch, pos, mode, tgt, req);
        delta = d - cur;
        if (sign3(d) != sign3(cur) || delta > longint'(margin) ||
            delta < -longint'(margin)) begin
          held_duty[ch] = 17'(d);
          r.rewritten = 1'b1;
        end
      end else begin
        // Idle and the spare mode code both clear the history.
        idle_ticks++;
        prev_err[ch] = 0;
        older_err[ch] = 0;
        duty_sum[ch] = 0;
        if (cur != 0) begin
          held_duty[ch] = 0;
          r.rewritten = 1'b1;
        end
      end
      h = longint'(held_duty[ch]);
      r.duty = held_duty[ch];
      r.fwd = (h > 0) ? 16'(h) : 16'd0;
      r.rev = (h < 0) ? 16'(-h) : 16'd0;
      expected_ticks.push_back(r);
    endfunction

    function void check_tick(logic [55:0] data, logic [0:0] user);
      tick_result_t got, want;
      got.ch = user[0];
      got.duty = data[16:0];
      got.rewritten = data[17];
      got.fwd = data[33:18];
      got.rev = data[49:34];
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ch=%0d duty=%0d rw=%0d fwd=%0d rev=%0d", $realtime,
                 got.ch, got.duty, got.rewritten, got.fwd, got.rev);
        return;
      end
      want = expected_ticks.pop_front();
      checked++;
      if (want.rewritten) rewrites++;
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch expected ch=%0d duty=%0d rw=%0d fwd=%0d rev=%0d",
                 $realtime, want.ch, want.duty, want.rewritten, want.fwd, want.rev);
        $display("%0t:          actual   ch=%0d duty=%0d rw=%0d fwd=%0d rev=%0d",
                 $realtime, got.ch, got.duty, got.rewritten, got.fwd, got.rev);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  servo_pid_checker sb = new();

  // Idling controls: the sender may leave gaps and the sink may stall, each in
  // bursts; both are switched off for the final phase.
  bit sender_gaps = 1'b0;
  bit sink_stalls = 1'b0;
  bit quiet_tail = 1'b0;
  int items_sent = 0;
  int stall_left = 0;

  servo_incremental_pid_unit DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // All handshakes are observed at the rising edge, before the block's own
  // registers move, so the sampled values are the ones the edge acted on.
  // A request is noted before any result is checked at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_register(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_tick(s_axis_tuser[0], s_axis_tdata[11:0], s_axis_tuser[2:1],
                     s_axis_tdata[23:12], s_axis_tdata[40:24]);
      if (m_axis_tvalid && m_axis_tready) sb.check_tick(m_axis_tdata, m_axis_tuser);
    end
  end

  // Result sink: ready drops in random bursts while stalls are on.
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_stalls && !quiet_tail && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  // Offers one control tick and returns at the falling edge after it is taken.
  // Valid stays high between back-to-back requests.
  task automatic send_tick(input bit ch, input int pos, input bit [1:0] mode,
                           input int tgt, input int req);
    if (sender_gaps && !quiet_tail && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, 17'(req), 12'(tgt), 12'(pos)};
    s_axis_tuser <= {mode, ch};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
  endtask

  // Stops offering ticks and waits until every predicted result has arrived.
  // Every tick yields a result, so an empty queue means the pipeline is empty.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_ticks.size() != 0) @(negedge clk);
  endtask

  // Writes all five registers back to back; only called with the block idle.
  task automatic write_settings(input bit [15:0] dl, input bit [11:0] lo,
                                input bit [11:0] hi, input bit [7:0] db,
                                input bit [9:0] mg);
    bit [2:0]  regs[5];
    bit [15:0] vals[5];
    regs = '{CFG_DUTY_LIMIT, CFG_POSITION_LOW, CFG_POSITION_HIGH,
             CFG_ERROR_DEADBAND, CFG_REWRITE_MARGIN};
    vals = '{dl, 16'(lo), 16'(hi), 16'(db), 16'(mg)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Register value biased toward zero and the top of its range.
  function automatic int pick_value(int top);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic random_settings();
    int lo, hi, tmp;
    lo = $urandom_range(0, 1500);
    hi = $urandom_range(2500, 4095);
    if ($urandom_range(0, 7) == 0) begin
      lo = 0;
      hi = 4095;
    end
    // Now and then the limits are crossed on purpose.
    if ($urandom_range(0, 5) == 0) begin
      tmp = lo;
      lo = hi;
      hi = tmp;
    end
    write_settings(16'(pick_value(65535)), 12'(lo), 12'(hi),
                   8'($urandom_range(0, 3) == 0 ? pick_value(255) : $urandom_range(0, 40)),
                   10'($urandom_range(0, 3) == 0 ? pick_value(1023) : $urandom_range(0, 80)));
  endtask

  // A tick with every field random, including the spare mode code.
  task automatic noise_tick();
    send_tick($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 3),
              $urandom_range(0, 4095), $urandom_range(0, 131071));
  endtask

  // A run of ticks on one channel whose position follows the commanded goal,
  // roughly like a real servo, so the PID history builds up across ticks.
  task automatic run_sequence();
    bit       ch;
    bit [1:0] mode;
    int       len, pos, tgt, req, goal;
    ch = $urandom_range(0, 1);
    mode = ($urandom_range(0, 2) == 0) ? MODE_DUTY : MODE_ANGLE;
    len = $urandom_range(5, 30);
    pos = $urandom_range(0, 4095);
    tgt = $urandom_range(0, 4095);
    req = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
    if ($urandom_range(0, 1) == 0) req = -req;
    if ($urandom_range(0, 19) == 0) req = -65536;
    if ($urandom_range(0, 19) == 0) req = 0;
    sender_gaps = $urandom_range(0, 2) != 0;
    sink_stalls = $urandom_range(0, 2) != 0;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) noise_tick();
      send_tick(ch, pos, mode, tgt, req);
      if (mode == MODE_DUTY) goal = (req > 0) ? sb.pos_high : ((req < 0) ? sb.pos_low : pos);
      else goal = tgt;
      pos = pos + (goal - pos) / int'($urandom_range(2, 8)) + int'($urandom_range(0, 40)) - 20;
      if (pos < 0) pos = 0;
      if (pos > 4095) pos = 4095;
    end
    if ($urandom_range(0, 3) == 0) send_tick(ch, pos, MODE_IDLE, tgt, req);
  endtask

  initial begin
    int goal;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: quiet loop, far targets beyond
    // both limits, idle, full-scale and zero duty requests, the spare mode and
    // errors on both sides of the deadband edge.
    send_tick(0, 2000, MODE_ANGLE, 2000, 0);
    send_tick(0, 0, MODE_ANGLE, 4095, 0);
    send_tick(0, 4095, MODE_ANGLE, 0, 0);
    send_tick(0, 0, MODE_ANGLE, 4095, 0);
    send_tick(0, 0, MODE_IDLE, 4095, 0);
    send_tick(1, 0, MODE_DUTY, 0, 65535);
    send_tick(1, 4095, MODE_DUTY, 0, -65536);
    send_tick(1, 1234, MODE_DUTY, 0, 0);
    send_tick(1, 500, MODE_DUTY, 0, 1);
    send_tick(1, 500, 2'd3, 4095, -1);
    send_tick(0, 2005, MODE_ANGLE, 2000, 0);
    send_tick(0, 2000, MODE_ANGLE, 2009, 0);
    send_tick(0, 2000, MODE_ANGLE, 2010, 0);

    // Crossed position limits, no deadband, no margin, widest angle limit.
    wait_idle();
    write_settings(16'hFFFF, 12'd3000, 12'd1000, 8'd0, 10'd0);
    send_tick(0, 500, MODE_ANGLE, 4095, 0);
    send_tick(0, 3500, MODE_ANGLE, 0, 0);
    send_tick(1, 2000, MODE_DUTY, 0, 100);
    send_tick(1, 2000, MODE_DUTY, 0, -100);
    send_tick(0, 3500, MODE_IDLE, 0, 0);

    // Full position span, widest deadband and margin, zero angle limit.
    wait_idle();
    write_settings(16'd0, 12'd0, 12'd4095, 8'hFF, 10'h3FF);
    send_tick(0, 0, MODE_ANGLE, 4095, 0);
    send_tick(1, 0, MODE_DUTY, 0, 65535);
    send_tick(1, 4095, MODE_DUTY, 0, -65535);
    send_tick(0, 0, 2'd3, 0, 0);

    // Random phases, each under fresh settings; the last one runs without
    // any gaps or stalls.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      random_settings();
      quiet_tail = (phase == RANDOM_PHASES - 1);
      goal = items_sent + TICKS_PER_PHASE;
      while (items_sent < goal) begin
        if ($urandom_range(0, 4) == 0) noise_tick();
        else run_sequence();
      end
    end

    // Drain, then give the pipeline time to show any stray result.
    wait_idle();
    repeat (20) @(negedge clk);

    $display("summary: %0d ticks sent, %0d results checked, %0d rewrites, %0d register writes",
             items_sent, sb.checked, sb.rewrites, sb.writes);
    $display("summary: %0d angle, %0d duty and %0d idle ticks, %0d mismatches",
             sb.angle_ticks, sb.duty_ticks, sb.idle_ticks, sb.errors);
    if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
